/* hw/rtl/dettrig_pkg.sv */
package dettrig_pkg;

   // Field widths fixed by the interface.
   localparam int FRAME_W = 32;
   localparam int TIME_W  = 63;
   localparam int CFG_W   = 16;

   // Serial datapath: timestamps are carried as 64-bit words, eight bits per cycle.
   localparam int WORD_W    = 64;
   localparam int DIGIT_W   = 8;
   localparam int N_DIGITS  = WORD_W / DIGIT_W;
   localparam int CNT_W     = $clog2(N_DIGITS);
   localparam int DIV_STEPS = FRAME_W / N_DIGITS;

   // Quiet-gap limit: seconds times microseconds per second.
   localparam int US_W    = 20;
   localparam int LIMIT_W = CFG_W + US_W;
   localparam logic [US_W-1:0] US_PER_SECOND = 20'd1000000;

   localparam logic [CFG_W-1:0] SAVE_RATE_RESET = 16'd1;
   localparam logic [CFG_W-1:0] INTERVAL_RESET  = 16'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_MOTION = 2'd1,
      KIND_FACE   = 2'd2
   } alert_kind_type;

   typedef enum logic [1:0] {
      NOTIFY_NONE    = 2'd0,
      NOTIFY_WARNING = 2'd1,
      NOTIFY_DANGER  = 2'd2
   } notify_type;

   typedef enum logic {
      CSR_SAVE_RATE      = 1'b0,
      CSR_EVENT_INTERVAL = 1'b1
   } csr_index_type;

endpackage

/* hw/rtl/detection_event_trigger.sv */
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | motion_seen, face_seen, frame_number, time_us
// rsp     | out       | rsp_valid/rsp_ready | take_snapshot, raise_alert, alert_kind,
//         |           |                     | alert_time_us, event_closed, event_open
// csr     | in        | csr_we (no wait)    | csr_index, csr_wdata
//
// An item is accepted, worked digit by digit in ST_RUN and finished in ST_DONE; its result
// becomes valid in the same cycle as req_ready is back, so no item is accepted until the
// last is through. The run walks the 64-bit timestamp words at eight bits a cycle; the
// remainder unit retires four frame-number bits a cycle alongside. Reset is synchronous.
// rsp_ready held low stalls only the finishing cycle: one result can wait in the output
// register while the next item is accepted and worked on.
module detection_event_trigger (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_motion_seen,
   input  logic                             req_face_seen,
   input  logic [dettrig_pkg::FRAME_W-1:0]  req_frame_number,
   input  logic [dettrig_pkg::TIME_W-1:0]   req_time_us,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_take_snapshot,
   output logic                             rsp_raise_alert,
   output logic [1:0]                       rsp_alert_kind,
   output logic [dettrig_pkg::TIME_W-1:0]   rsp_alert_time_us,
   output logic                             rsp_event_closed,
   output logic                             rsp_event_open,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [dettrig_pkg::CFG_W-1:0]    csr_wdata
);
   import dettrig_pkg::*;

   // Control state.
   seq_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic               rsp_valid_ff;
   logic               org_nz_ff;   // the time origin has been latched
   logic               es_nz_ff;    // an event is open
   notify_type         nl_ff, nl_in;
   logic [CFG_W-1:0]   save_rate_ff;
   logic [CFG_W-1:0]   interval_ff;

   // Datapath registers.
   logic [LIMIT_W-1:0] lim_now;
   logic [WORD_W-1:0]  t_ff, es_ff, org_ff, lim_sr_ff, atime_sr_ff;
   logic [FRAME_W-1:0] frame_sr_ff;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic               bor1_ff, bor2_ff, bor3_ff, dnz_ff, tnz_ff;
   logic               mot_ff, face_ff;

   // Result register.
   logic               snap_ff, alert_ff, closed_ff, open_ff;
   logic [1:0]         kind_ff;
   logic [TIME_W-1:0]  atime_ff;

   logic               accept, run, finish;

   // Digit datapath.
   logic [DIGIT_W-1:0] t_d, es_d, org_d, lim_d;
   logic [DIGIT_W:0]   d1, d2, d3;

   // Finishing decisions.
   logic               det, first, multiple, warn, snap, skip, alert, timing, close_ev;
   logic               es_nz_p, es_nz_in, es_upd;
   logic [1:0]         kind_in;

   assign accept = req_valid && req_ready;

   // --------------------------------------------------------------------------------------
   // Sequencer: idle, the digit run state, then a finishing state that waits for room in the
   // output register.
   // --------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      run       = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            run = 1'b1;
            if (cnt_ff == CNT_W'(N_DIGITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------------------------------------
   // One digit per cycle. The timestamp, event start and origin words rotate, so that after the
   // last digit they hold their loaded values again. Three borrow chains run side by side:
   // frame time minus event start, that difference minus the gap limit, and event start
   // minus the origin, whose digits are collected as the alert time.
   // --------------------------------------------------------------------------------------
   assign t_d   = t_ff[DIGIT_W-1:0];
   assign es_d  = es_ff[DIGIT_W-1:0];
   assign org_d = org_ff[DIGIT_W-1:0];
   assign lim_d = lim_sr_ff[DIGIT_W-1:0];

   assign d1 = {1'b0, t_d} - {1'b0, es_d} - {{DIGIT_W{1'b0}}, bor1_ff};
   assign d2 = {1'b0, d1[DIGIT_W-1:0]} - {1'b0, lim_d} - {{DIGIT_W{1'b0}}, bor2_ff};
   assign d3 = {1'b0, es_d} - {1'b0, org_d} - {{DIGIT_W{1'b0}}, bor3_ff};

   // Gap limit in microseconds from the current interval, loaded as an item is accepted.
   assign lim_now = LIMIT_W'({{US_W{1'b0}}, interval_ff} * {{CFG_W{1'b0}}, US_PER_SECOND});

   // Restoring remainder of the frame number by the save rate, four bits per cycle.
   always_comb begin
      logic [CFG_W:0]   trial;
      logic [CFG_W-1:0] rem_v;
      rem_v = rem_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {rem_v, frame_sr_ff[FRAME_W-1-i]};
         if (trial >= {1'b0, save_rate_ff}) begin
            trial = trial - {1'b0, save_rate_ff};
         end
         rem_v = trial[CFG_W-1:0];
      end
      rem_in = rem_v;
   end

   // --------------------------------------------------------------------------------------
   // Finishing decisions. By now es_ff holds the event start as seen by this frame (the frame
   // time if it opened the event) and org_ff the time origin after latching.
   // --------------------------------------------------------------------------------------
   always_comb begin
      det      = mot_ff || face_ff;
      first    = !dnz_ff;
      multiple = (save_rate_ff != '0) && (rem_ff == '0);
      warn     = (nl_ff == NOTIFY_WARNING);
      snap     = det && (first || multiple);
      // A snapshot frame after a warning with only motion neither alerts nor touches timing.
      skip     = snap && warn && !face_ff;
      alert    = snap && (first || warn) && !skip;
      kind_in  = face_ff ? KIND_FACE : KIND_MOTION;
      timing   = det && !skip;
      // The gap ends the event when it is not negative and reaches the limit.
      close_ev = timing && !bor1_ff && !bor2_ff;
      es_nz_p  = es_nz_ff || tnz_ff;
      es_upd   = timing && !close_ev;

      nl_in = nl_ff;
      if (alert) begin
         nl_in = face_ff ? NOTIFY_DANGER : NOTIFY_WARNING;
      end
      if (close_ev) begin
         nl_in = NOTIFY_NONE;
      end

      if (!det) begin
         es_nz_in = es_nz_ff;
      end else if (close_ev) begin
         es_nz_in = 1'b0;
      end else if (es_upd) begin
         // The start follows the frame time, which may itself be zero.
         es_nz_in = tnz_ff;
      end else begin
         es_nz_in = es_nz_p;
      end
   end

   // --------------------------------------------------------------------------------------
   // Control registers and configuration.
   // --------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         org_nz_ff    <= 1'b0;
         es_nz_ff     <= 1'b0;
         nl_ff        <= NOTIFY_NONE;
         save_rate_ff <= SAVE_RATE_RESET;
         interval_ff  <= INTERVAL_RESET;
      end else begin
         if (accept) begin
            cnt_ff <= '0;
         end else if (run) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            org_nz_ff    <= org_nz_ff || tnz_ff;
            es_nz_ff     <= es_nz_in;
            nl_ff        <= nl_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SAVE_RATE:      save_rate_ff <= csr_wdata;
               CSR_EVENT_INTERVAL: interval_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------------------
   // Datapath registers.
   // --------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff <= {1'b0, req_time_us};
         if (!org_nz_ff) begin
            org_ff <= {1'b0, req_time_us};
         end
         if ((req_motion_seen || req_face_seen) && !es_nz_ff) begin
            es_ff <= {1'b0, req_time_us};
         end
         lim_sr_ff   <= WORD_W'(lim_now);
         frame_sr_ff <= req_frame_number;
         rem_ff      <= '0;
         bor1_ff     <= 1'b0;
         bor2_ff     <= 1'b0;
         bor3_ff     <= 1'b0;
         dnz_ff      <= 1'b0;
         tnz_ff      <= 1'b0;
         mot_ff      <= req_motion_seen;
         face_ff     <= req_face_seen;
      end else if (run) begin
         t_ff        <= {t_d, t_ff[WORD_W-1:DIGIT_W]};
         es_ff       <= {es_d, es_ff[WORD_W-1:DIGIT_W]};
         org_ff      <= {org_d, org_ff[WORD_W-1:DIGIT_W]};
         lim_sr_ff   <= {{DIGIT_W{1'b0}}, lim_sr_ff[WORD_W-1:DIGIT_W]};
         atime_sr_ff <= {d3[DIGIT_W-1:0], atime_sr_ff[WORD_W-1:DIGIT_W]};
         frame_sr_ff <= {frame_sr_ff[FRAME_W-1-DIV_STEPS:0], {DIV_STEPS{1'b0}}};
         rem_ff      <= rem_in;
         bor1_ff     <= d1[DIGIT_W];
         bor2_ff     <= d2[DIGIT_W];
         bor3_ff     <= d3[DIGIT_W];
         dnz_ff      <= dnz_ff || (d1[DIGIT_W-1:0] != '0);
         tnz_ff      <= tnz_ff || (t_d != '0);
      end else if (finish) begin
         if (es_upd) begin
            es_ff <= t_ff;
         end
      end

      if (finish) begin
         snap_ff   <= snap;
         alert_ff  <= alert;
         kind_ff   <= alert ? kind_in : KIND_NONE;
         atime_ff  <= alert ? atime_sr_ff[TIME_W-1:0] : '0;
         closed_ff <= close_ev;
         open_ff   <= es_nz_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_take_snapshot = snap_ff;
   assign rsp_raise_alert   = alert_ff;
   assign rsp_alert_kind    = kind_ff;
   assign rsp_alert_time_us = atime_ff;
   assign rsp_event_closed  = closed_ff;
   assign rsp_event_open    = open_ff;

   // --------------------------------------------------------------------------------------
   // Assertions.
   // --------------------------------------------------------------------------------------
   a_alert_has_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_raise_alert |->
         (rsp_alert_kind == KIND_MOTION) || (rsp_alert_kind == KIND_FACE))
      else $error("alert without a kind");

   a_no_alert_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_raise_alert |->
         (rsp_alert_kind == KIND_NONE) && (rsp_alert_time_us == '0))
      else $error("alert fields set without an alert");

   a_alert_needs_snap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_raise_alert |-> rsp_take_snapshot)
      else $error("alert on a frame without a snapshot");

   a_closed_not_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_closed |-> !rsp_event_open)
      else $error("closed event still reported open");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (cnt_ff == '0))
      else $error("accepted item did not start the digit sequence");

endmodule
